@@ src/signed_int_to_base_digits_core_macros.svh @@
// assertion macros used by the checker file of the digit converter
`ifndef SIGNED_INT_TO_BASE_DIGITS_CORE_MACROS_SVH
`define SIGNED_INT_TO_BASE_DIGITS_CORE_MACROS_SVH

// clocked assertion, switched off while reset is held
`define SITBD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SITBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/sitbd_pkg.sv @@
// shared constants and helper functions of the digit converter
package sitbd_pkg;

  // default for the largest usable base
  localparam int MaxDigitsDef = 16;

  // characters with a fixed meaning
  localparam logic [7:0] MinusChar = 8'h2D;
  localparam logic [7:0] PlusChar  = 8'h2B;

  // configuration register indexes
  localparam logic [1:0] CfgDigitCount  = 2'd0;
  localparam logic [1:0] CfgAlphabetLow = 2'd1;
  localparam logic [1:0] CfgAlphabetHi  = 2'd2;

  // smallest base that can be valid
  localparam logic [4:0] MinBase = 5'd2;

  // character for one digit from the packed 16 character alphabet
  function automatic logic [7:0] alpha_char(logic [127:0] alpha, logic [3:0] idx);
    return alpha[{idx, 3'b000} +: 8];
  endfunction

  // floor(2^32 / base), used for the reciprocal divide
  function automatic logic [31:0] base_recip(logic [4:0] b);
    logic [31:0] r;
    unique case (b)
      5'd2:    r = 32'h8000_0000;
      5'd3:    r = 32'h5555_5555;
      5'd4:    r = 32'h4000_0000;
      5'd5:    r = 32'h3333_3333;
      5'd6:    r = 32'h2AAA_AAAA;
      5'd7:    r = 32'h2492_4924;
      5'd8:    r = 32'h2000_0000;
      5'd9:    r = 32'h1C71_C71C;
      5'd10:   r = 32'h1999_9999;
      5'd11:   r = 32'h1745_D174;
      5'd12:   r = 32'h1555_5555;
      5'd13:   r = 32'h13B1_3B13;
      5'd14:   r = 32'h1249_2492;
      5'd15:   r = 32'h1111_1111;
      5'd16:   r = 32'h1000_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

@@ src/signed_int_to_base_digits_core.sv @@
// top level: signed 32-bit value to text in a configurable base
// flow: accept a value in idle, check the alphabet one character at a time, then find
//   each digit in a StMul/StFix pass on the shared reciprocal multiplier, then send
//   1 item per cycle out while not stalled; values pass one at a time through the
//   single multiplier loop and the one-entry output register, a new one taken only in idle
// reset: sequencer, output valid and the configuration registers clear to zero
module signed_int_to_base_digits_core
  import sitbd_pkg::*;
#(
  parameter int MAX_DIGITS = MaxDigitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] value_i,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         char_out_o,
  output logic               is_last_o
);

  localparam int DigW = $clog2(MAX_DIGITS);

  // sequencer states
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCheck = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StFix   = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  logic [4:0]  digit_count_q;
  logic [63:0] alphabet_low_q;
  logic [63:0] alphabet_high_q;
  logic [127:0] alpha;

  logic [2:0]  state_q, state_d;
  logic [31:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [3:0]  chk_q, chk_d;
  logic [4:0]  nd_q, nd_d;
  logic [63:0] prod_q;
  logic [DigW-1:0] digits_q [32];

  logic        out_valid_q, out_valid_d;
  logic [7:0]  char_q, char_d;
  logic        last_q, last_d;

  logic        in_acc;
  logic        base_ok;
  logic [3:0]  base_top;
  logic [7:0]  chk_char;
  logic        dup;
  logic        chk_bad;
  logic [31:0] q_est;
  logic [31:0] q_base;
  logic [31:0] rem;
  logic        rem_over;
  logic [31:0] rem_fix;
  logic [31:0] q_fix;
  logic        out_load;
  logic        dig_we;

  assign alpha    = {alphabet_high_q, alphabet_low_q};
  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign base_ok  = (digit_count_q >= MinBase) && (digit_count_q <= 5'(MAX_DIGITS));
  assign base_top = 4'(digit_count_q - 5'd1);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_count_q   <= '0;
      alphabet_low_q  <= '0;
      alphabet_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDigitCount:  digit_count_q   <= cfg_data_i[4:0];
        CfgAlphabetLow: alphabet_low_q  <= cfg_data_i;
        CfgAlphabetHi:  alphabet_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // alphabet check of one character against the later ones and the sign characters
  always_comb begin
    chk_char = alpha_char(alpha, chk_q);
    dup = 1'b0;
    for (int j = 0; j < 16; j++) begin
      if ((5'(j) > {1'b0, chk_q}) && (5'(j) < digit_count_q) &&
          (alpha_char(alpha, 4'(j)) == chk_char)) begin
        dup = 1'b1;
      end
    end
    chk_bad = dup || (chk_char == PlusChar) || (chk_char == MinusChar);
  end

  // quotient estimate correction, off the registered product
  assign q_est    = prod_q[63:32];
  assign q_base   = 32'(q_est * {27'b0, digit_count_q});
  assign rem      = mag_q - q_base;
  assign rem_over = (rem >= {27'b0, digit_count_q});
  assign rem_fix  = rem_over ? (rem - {27'b0, digit_count_q}) : rem;
  assign q_fix    = rem_over ? (q_est + 32'd1) : q_est;

  assign out_load = (state_q == StEmit) && (!out_valid_q || !out_stall_i);
  assign dig_we   = (state_q == StFix);

  // sequencer
  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    chk_d   = chk_q;
    nd_d    = nd_q;
    char_d  = char_q;
    last_d  = last_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          neg_d = value_i[31];
          mag_d = value_i[31] ? (32'd0 - value_i) : value_i;
          chk_d = '0;
          nd_d  = '0;
          if (base_ok) begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (chk_bad) begin
          state_d = StIdle;
        end else if (chk_q == base_top) begin
          state_d = StMul;
        end else begin
          chk_d = chk_q + 4'd1;
        end
      end
      StMul: begin
        state_d = StFix;
      end
      StFix: begin
        mag_d = q_fix;
        if ((q_fix == 32'd0) || (nd_q == 5'd31)) begin
          state_d = StEmit;
        end else begin
          nd_d    = nd_q + 5'd1;
          state_d = StMul;
        end
      end
      StEmit: begin
        if (out_load) begin
          if (neg_q) begin
            char_d = MinusChar;
            last_d = 1'b0;
            neg_d  = 1'b0;
          end else begin
            char_d = alpha_char(alpha, 4'(digits_q[nd_q]));
            last_d = (nd_q == 5'd0);
            if (nd_q == 5'd0) begin
              state_d = StIdle;
            end else begin
              nd_d = nd_q - 5'd1;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      chk_q       <= '0;
      nd_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      neg_q       <= neg_d;
      chk_q       <= chk_d;
      nd_q        <= nd_d;
    end
  end

  // datapath registers and shared multiplier
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
    prod_q <= {32'b0, mag_q} * {32'b0, base_recip(digit_count_q)};
    if (dig_we) begin
      digits_q[nd_q] <= rem_fix[DigW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign is_last_o   = last_q;

endmodule

@@ src/sitbd_checker.sv @@
// port checker of the digit converter and its bind
`include "signed_int_to_base_digits_core_macros.svh"

module sitbd_checker
  import sitbd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] char_out_o,
  input logic       is_last_o
);

  logic       out_wait;
  logic [8:0] out_item;
  logic       minus_out;

  assign out_wait  = out_valid_o && out_stall_i;
  assign out_item  = {char_out_o, is_last_o};
  assign minus_out = out_valid_o && (char_out_o == MinusChar);

  // a stalled item holds its payload
  `SITBD_ASSERT_CLK(a_out_hold, out_wait |=> out_valid_o && $stable(out_item), "stalled item changed")

  // a waiting input item stays offered until taken
  `SITBD_ASSERT_CLK(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i, "input item withdrawn")

  // the sign is never the final character
  `SITBD_ASSERT_CLK(a_minus_not_last, minus_out |-> !is_last_o, "minus sign flagged as last")

  // reset leaves no output item
  `SITBD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

bind signed_int_to_base_digits_core sitbd_checker u_sitbd_checker (.*);
